// ===== design/ahc_pkg.sv =====
package ahc_pkg;

	// Fixed field widths of the request and result words.
	localparam int KEY_W   = 64;
	localparam int DATA_W  = 64;
	localparam int TIME_W  = 32;
	localparam int SLOT_W  = 4;
	localparam int COUNT_W = 5;

	// Configuration port.
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;
	localparam int REG_IDX_LSB = 2;
	localparam logic REG_LIFETIME = 1'b0;
	localparam logic [TIME_W-1:0] LIFETIME_RESET = 32'd3600;

	// Request operations.
	typedef enum logic [1:0] {
		OP_TICK       = 2'd0,
		OP_LOOKUP     = 2'd1,
		OP_INSERT     = 2'd2,
		OP_INVALIDATE = 2'd3
	} opcode_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	// One cache entry as held in the entry memory.
	typedef struct packed {
		logic [KEY_W-1:0]  object_key;
		logic [KEY_W-1:0]  acl_key;
		logic [DATA_W-1:0] acl_data;
		logic [TIME_W-1:0] expiry;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic exec;
		logic scan_issue;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_last;
	} dp_sts_t;

endpackage

// ===== design/acl_handle_cache.sv =====
// Channel   | Handshake           | Fields
// ----------+---------------------+-----------------------------------------------
// request   | start, busy         | opcode, object_key, acl_key, acl_data, entry_good
// result    | done (strobe)       | hit, slot, found_acl_key, found_acl_data, removed_count
// config    | psel/penable/pready | paddr, pwrite, pwdata, prdata (lifetime_ticks at 0)
//
// A request word is taken when start is high and busy is low; one word is in work at a time.
// A tick or an insert passes the execute state and shows its result in the done state;
// a lookup or invalidate reads one entry per cycle from the entry memory in the scan state,
// then the drain state and the done state. Busy falls when the controller is back in idle.
// Reset clears the clock, the slot pointer and every valid bit at once; no clearing pass.
// The result strobe lasts one cycle and the receiver cannot stall it.
module acl_handle_cache
	import ahc_pkg::*;
#(
	parameter int CACHE_DEPTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            opcode,
	input  logic [KEY_W-1:0]      object_key,
	input  logic [KEY_W-1:0]      acl_key,
	input  logic [DATA_W-1:0]     acl_data,
	input  logic                  entry_good,
	output logic                  done,
	output logic                  hit,
	output logic [SLOT_W-1:0]     slot,
	output logic [KEY_W-1:0]      found_acl_key,
	output logic [DATA_W-1:0]     found_acl_data,
	output logic [COUNT_W-1:0]    removed_count,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	logic [TIME_W-1:0] lifetime_q;
	logic              reg_sel;
	dp_cmd_t           cmd;
	dp_sts_t           sts;

	// Register decode: one 32-bit register at byte address zero.
	assign reg_sel = (paddr[REG_IDX_LSB] == REG_LIFETIME);
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? lifetime_q : '0;

	// Lifetime register, written in the access cycle of a write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lifetime_q <= LIFETIME_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			lifetime_q <= pwdata;
		end
	end

	ahc_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.opcode(opcode),
		.sts   (sts),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	ahc_dp #(
		.CACHE_DEPTH(CACHE_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.lifetime      (lifetime_q),
		.opcode        (opcode),
		.object_key    (object_key),
		.acl_key       (acl_key),
		.acl_data      (acl_data),
		.entry_good    (entry_good),
		.hit           (hit),
		.slot          (slot),
		.found_acl_key (found_acl_key),
		.found_acl_data(found_acl_data),
		.removed_count (removed_count)
	);

endmodule

// ===== design/ahc_ram.sv =====
module ahc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Single write port, single registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/ahc_ctrl.sv =====
module ahc_ctrl
	import ahc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] opcode,
	input  dp_sts_t    sts,
	output dp_cmd_t    cmd,
	output logic       busy,
	output logic       done
);

	state_t state_q;
	state_t state_d;
	opcode_t op_in;

	assign op_in = opcode_t'(opcode);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state: ticks and inserts take the execute state, the others scan every entry.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (op_in == OP_TICK || op_in == OP_INSERT) begin
						state_d = ST_EXEC;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_EXEC: begin
				state_d = ST_DONE;
			end
			ST_SCAN: begin
				if (sts.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Outputs decoded from the state.
	always_comb begin
		cmd.accept     = (state_q == ST_IDLE) && start;
		cmd.exec       = (state_q == ST_EXEC);
		cmd.scan_issue = (state_q == ST_SCAN);
		busy           = (state_q != ST_IDLE);
		done           = (state_q == ST_DONE);
	end

`ifndef SYNTHESIS
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> busy && !done)
		else $error("accepted word did not make the block busy");

	a_scan_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && !sts.scan_last) |=> (state_q == ST_SCAN))
		else $error("scan left before the last entry was read");

	a_scan_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && sts.scan_last) |=> ##1 done)
		else $error("result not presented after the scan drained");
`endif

endmodule

// ===== design/ahc_dp.sv =====
module ahc_dp
	import ahc_pkg::*;
#(
	parameter int CACHE_DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	output dp_sts_t            sts,
	input  logic [TIME_W-1:0]  lifetime,
	input  logic [1:0]         opcode,
	input  logic [KEY_W-1:0]   object_key,
	input  logic [KEY_W-1:0]   acl_key,
	input  logic [DATA_W-1:0]  acl_data,
	input  logic               entry_good,
	output logic               hit,
	output logic [SLOT_W-1:0]  slot,
	output logic [KEY_W-1:0]   found_acl_key,
	output logic [DATA_W-1:0]  found_acl_data,
	output logic [COUNT_W-1:0] removed_count
);

	localparam int IDX_W = $clog2(CACHE_DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_DEPTH - 1);

	// Latched request word.
	opcode_t           op_q;
	logic [KEY_W-1:0]  okey_q;
	logic [KEY_W-1:0]  akey_q;
	logic [DATA_W-1:0] adata_q;
	logic              good_q;

	// Cache state held in flip-flops.
	logic [TIME_W-1:0]      clock_q;
	logic [IDX_W-1:0]       next_slot_q;
	logic [CACHE_DEPTH-1:0] valid_q;

	// Scan pointer and the compare stage behind the memory read.
	logic [IDX_W-1:0] scan_idx_q;
	logic             cmp_vld_s1;
	logic [IDX_W-1:0] cmp_idx_s1;

	// Result registers.
	logic               hit_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [KEY_W-1:0]   fkey_q;
	logic [DATA_W-1:0]  fdata_q;
	logic [COUNT_W-1:0] removed_q;

	// Memory access and compare terms.
	entry_t                  wr_entry;
	logic [ENTRY_W-1:0]      rd_word;
	entry_t                  rd_entry;
	logic [IDX_W-1:0]        ins_idx;
	logic                    ins_we;
	logic [TIME_W-1:0]       remain;
	logic                    live;
	logic                    okey_eq;
	logic                    akey_eq;
	logic [IDX_W+SLOT_W-1:0] cmp_idx_ext;
	logic [IDX_W+SLOT_W-1:0] ins_idx_ext;
	logic [IDX_W+SLOT_W-1:0] ptr_idx_ext;

	// Round-robin pointer advances before the write.
	assign ins_idx = (next_slot_q == LAST_IDX) ? '0 : next_slot_q + 1'b1;
	assign ins_we  = cmd.exec && (op_q == OP_INSERT) && good_q;

	always_comb begin
		wr_entry.object_key = okey_q;
		wr_entry.acl_key    = akey_q;
		wr_entry.acl_data   = adata_q;
		wr_entry.expiry     = clock_q + lifetime;
	end

	ahc_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(CACHE_DEPTH)
	) u_entry_ram (
		.clk  (clk),
		.we   (ins_we),
		.waddr(ins_idx),
		.wdata(wr_entry),
		.re   (cmd.scan_issue),
		.raddr(scan_idx_q),
		.rdata(rd_word)
	);

	assign rd_entry = entry_t'(rd_word);

	// An entry is live while its remaining time lies in one to the current lifetime.
	assign remain  = rd_entry.expiry - clock_q;
	assign live    = valid_q[cmp_idx_s1] && (remain != '0) && (remain <= lifetime);
	assign okey_eq = (rd_entry.object_key == okey_q);
	assign akey_eq = (rd_entry.acl_key == akey_q);

	// Slot numbers keep their low four bits.
	assign cmp_idx_ext = {{SLOT_W{1'b0}}, cmp_idx_s1};
	assign ins_idx_ext = {{SLOT_W{1'b0}}, ins_idx};
	assign ptr_idx_ext = {{SLOT_W{1'b0}}, next_slot_q};

	// Request latch.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q    <= opcode_t'(opcode);
			okey_q  <= object_key;
			akey_q  <= acl_key;
			adata_q <= acl_data;
			good_q  <= entry_good;
		end
	end

	// Clock, pointer, valid bits and scan control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q     <= '0;
			next_slot_q <= '0;
			valid_q     <= '0;
			scan_idx_q  <= '0;
			cmp_vld_s1  <= 1'b0;
		end else begin
			cmp_vld_s1 <= cmd.scan_issue;
			if (cmd.accept) begin
				scan_idx_q <= '0;
			end else if (cmd.scan_issue) begin
				scan_idx_q <= scan_idx_q + 1'b1;
			end
			if (cmd.exec && op_q == OP_TICK) begin
				clock_q <= clock_q + 1'b1;
			end
			if (ins_we) begin
				next_slot_q      <= ins_idx;
				valid_q[ins_idx] <= 1'b1;
			end
			if (cmp_vld_s1 && op_q == OP_INVALIDATE && live && (okey_eq || akey_eq)) begin
				valid_q[cmp_idx_s1] <= 1'b0;
			end
		end
	end

	// Compare stage index and result registers.
	always_ff @(posedge clk) begin
		cmp_idx_s1 <= scan_idx_q;
		if (cmd.accept) begin
			hit_q     <= 1'b0;
			slot_q    <= '0;
			fkey_q    <= '0;
			fdata_q   <= '0;
			removed_q <= '0;
		end else if (cmd.exec && op_q == OP_INSERT) begin
			slot_q <= good_q ? ins_idx_ext[SLOT_W-1:0] : ptr_idx_ext[SLOT_W-1:0];
		end else if (cmp_vld_s1) begin
			// The first live match of a lookup wins; later ones are ignored.
			if (op_q == OP_LOOKUP && live && okey_eq && !hit_q) begin
				hit_q   <= 1'b1;
				slot_q  <= cmp_idx_ext[SLOT_W-1:0];
				fkey_q  <= rd_entry.acl_key;
				fdata_q <= rd_entry.acl_data;
			end
			if (op_q == OP_INVALIDATE && live && (okey_eq || akey_eq)) begin
				removed_q <= removed_q + 1'b1;
			end
		end
	end

	assign sts.scan_last = (scan_idx_q == LAST_IDX);

	assign hit            = hit_q;
	assign slot           = slot_q;
	assign found_acl_key  = fkey_q;
	assign found_acl_data = fdata_q;
	assign removed_count  = removed_q;

`ifndef SYNTHESIS
	a_no_exec_during_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> !cmp_vld_s1)
		else $error("entry compare in flight during a tick or insert");

	a_insert_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ins_we |=> (valid_q[next_slot_q] && next_slot_q != $past(next_slot_q)))
		else $error("insert did not advance the pointer and mark its slot");

	a_tick_advances_clock: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && op_q == OP_TICK) |=> (clock_q == $past(clock_q) + 1'b1))
		else $error("tick did not advance the clock by one");
`endif

endmodule
